[hw/rtl/supersample_box_downscale_macros.svh]
// Assertion macros used by the supersample box downscale checker.
`ifndef SUPERSAMPLE_BOX_DOWNSCALE_MACROS_SVH
`define SUPERSAMPLE_BOX_DOWNSCALE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SSBD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssbd check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SSBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssbd check failed");

`endif

[hw/rtl/ssbd_pkg.sv]
// Types, constants and the reciprocal table of the supersample box downscale.
`timescale 1ns / 1ps
`default_nettype none

package ssbd_pkg;

    localparam int NUM_CH       = 3;
    localparam int CHANNEL_BITS = 16;
    localparam int MAX_SCALE    = 8;
    localparam int MAX_OUT_HEIGHT = 4096;

    localparam int SCALE_W  = 4;
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 13;
    localparam int DIM_W    = 13;
    localparam int SUB_W    = 3;
    localparam int COL_W    = 12;
    localparam int ROW_W    = 12;
    localparam int RUN_W    = 19;
    localparam int SUM_W    = 22;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    // Gain 1.05 = 21 / 20; the 1/4 of 1/20 and the Q8.8 fraction make a shift.
    localparam int GAIN_NUM    = 21;
    localparam int GAIN_SHIFT  = 10;
    localparam int GAIN_W      = SUM_W + 5;
    localparam int SCALED_W    = GAIN_W - GAIN_SHIFT;
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 26;
    localparam int PROD_W      = SCALED_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam int PIX_W       = 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_SCALE  = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } reg_idx_t;

    // Clamped configuration as seen by the datapath.
    typedef struct packed {
        logic [SCALE_W-1:0] f;
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
    } cfg_t;

    // One finished block-row segment for the back end.
    typedef struct packed {
        logic [COL_W-1:0]             col;
        logic [NUM_CH-1:0][RUN_W-1:0] run;
        logic                         use_mem;
        logic                         emit;
        logic                         row_end;
        logic                         frame_end;
    } cmd_t;

    // ceil(2^26 / (5 * f * f)); exact floor division for 17-bit dividends.
    function automatic logic [RECIP_W-1:0] recip(input logic [SCALE_W-1:0] f);
        logic [RECIP_W-1:0] m;
        case (f)
            4'd2:    m = 24'd3355444;
            4'd3:    m = 24'd1491309;
            4'd4:    m = 24'd838861;
            4'd5:    m = 24'd536871;
            4'd6:    m = 24'd372828;
            4'd7:    m = 24'd273914;
            4'd8:    m = 24'd209716;
            default: m = 24'd13421773;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/ssbd_queue.sv]
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module ssbd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire ssbd_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output ssbd_pkg::cmd_t     head,
    output logic               full,
    output logic               empty
);

    ssbd_pkg::cmd_t                     entry_reg [ssbd_pkg::QUEUE_DEPTH];
    logic [ssbd_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [ssbd_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [ssbd_pkg::QCNT_W-1:0]        count_reg, count_next;
    logic                               do_push, do_pop;

    assign full    = (count_reg == ssbd_pkg::QCNT_W'(ssbd_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ssbd_front.sv]
// Front end: takes pixels, builds horizontal runs and tracks the block position.
`timescale 1ns / 1ps
`default_nettype none

module ssbd_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               restart,
    input  wire ssbd_pkg::cfg_t                     cfg,
    input  wire logic                               pixel_valid,
    output logic                                    pixel_ready,
    input  wire logic [ssbd_pkg::CHANNEL_BITS-1:0]  red_in,
    input  wire logic [ssbd_pkg::CHANNEL_BITS-1:0]  green_in,
    input  wire logic [ssbd_pkg::CHANNEL_BITS-1:0]  blue_in,
    input  wire logic                               q_full,
    output logic                                    push,
    output ssbd_pkg::cmd_t                          cmd
);

    logic [ssbd_pkg::NUM_CH-1:0][ssbd_pkg::CHANNEL_BITS-1:0] pix;
    logic [ssbd_pkg::NUM_CH-1:0][ssbd_pkg::RUN_W-1:0]        run_reg, run_next, run_sum;
    logic [ssbd_pkg::SUB_W-1:0]  sub_col_reg, sub_col_next;
    logic [ssbd_pkg::SUB_W-1:0]  sub_row_reg, sub_row_next;
    logic [ssbd_pkg::COL_W-1:0]  out_col_reg, out_col_next;
    logic [ssbd_pkg::ROW_W-1:0]  out_row_reg, out_row_next;
    logic accept, seg_end, last_col, last_row, last_sub_row;

    assign pix = {blue_in, green_in, red_in};

    assign pixel_ready  = !q_full;
    assign accept       = pixel_valid && pixel_ready;
    assign seg_end      = (ssbd_pkg::SCALE_W'(sub_col_reg) + ssbd_pkg::SCALE_W'(1)) >= cfg.f;
    assign last_sub_row = (ssbd_pkg::SCALE_W'(sub_row_reg) + ssbd_pkg::SCALE_W'(1)) >= cfg.f;
    assign last_col     = (ssbd_pkg::DIM_W'(out_col_reg) + ssbd_pkg::DIM_W'(1)) >= cfg.w;
    assign last_row     = (ssbd_pkg::DIM_W'(out_row_reg) + ssbd_pkg::DIM_W'(1)) >= cfg.h;

    // running horizontal sums including the current pixel
    always_comb
    begin
        for (int c = 0; c < ssbd_pkg::NUM_CH; c++)
        begin
            run_sum[c] = run_reg[c] + ssbd_pkg::RUN_W'(pix[c]);
        end
    end

    // segment request to the back end
    assign push          = accept && seg_end;
    assign cmd.col       = out_col_reg;
    assign cmd.run       = run_sum;
    assign cmd.use_mem   = (sub_row_reg != '0);
    assign cmd.emit      = last_sub_row;
    assign cmd.row_end   = last_col;
    assign cmd.frame_end = last_col && last_row;

    // position counters
    always_comb
    begin
        run_next     = run_reg;
        sub_col_next = sub_col_reg;
        sub_row_next = sub_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (restart)
        begin
            run_next     = '0;
            sub_col_next = '0;
            sub_row_next = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (accept)
        begin
            if (!seg_end)
            begin
                run_next     = run_sum;
                sub_col_next = sub_col_reg + 1'b1;
            end
            else
            begin
                run_next     = '0;
                sub_col_next = '0;
                if (!last_col)
                begin
                    out_col_next = out_col_reg + 1'b1;
                end
                else
                begin
                    out_col_next = '0;
                    if (!last_sub_row)
                    begin
                        sub_row_next = sub_row_reg + 1'b1;
                    end
                    else
                    begin
                        sub_row_next = '0;
                        out_row_next = last_row ? '0 : out_row_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= '0;
            sub_col_reg <= '0;
            sub_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            run_reg     <= run_next;
            sub_col_reg <= sub_col_next;
            sub_row_reg <= sub_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ssbd_back.sv]
// Back end: column-sum memory, block accumulation and the scaled resolve.
`timescale 1ns / 1ps
`default_nettype none

module ssbd_back #(
    parameter int MAX_OUT_WIDTH = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [ssbd_pkg::SCALE_W-1:0] f,
    input  wire logic                        q_empty,
    output logic                             q_pop,
    input  wire ssbd_pkg::cmd_t              q_head,
    output logic                             result_valid,
    input  wire logic                        result_ready,
    output logic [ssbd_pkg::PIX_W-1:0]       red_out,
    output logic [ssbd_pkg::PIX_W-1:0]       green_out,
    output logic [ssbd_pkg::PIX_W-1:0]       blue_out,
    output logic                             row_end,
    output logic                             frame_end
);

    localparam int IDXW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_OUT
    } state_t;

    typedef logic [ssbd_pkg::NUM_CH-1:0][ssbd_pkg::SUM_W-1:0] sums_t;

    state_t         state_reg;
    ssbd_pkg::cmd_t cmd_reg;
    sums_t          mem [MAX_OUT_WIDTH];
    sums_t          rd_reg;
    sums_t          tot, tot_reg;
    logic [ssbd_pkg::NUM_CH-1:0][ssbd_pkg::PROD_W-1:0] prod, prod_reg;
    logic [ssbd_pkg::NUM_CH-1:0][ssbd_pkg::PIX_W-1:0]  sat, pix_reg;
    logic [ssbd_pkg::GAIN_W-1:0]   gained;
    logic [ssbd_pkg::SCALED_W-1:0] scaled;
    logic [ssbd_pkg::QUOT_W-1:0]   quot;
    logic [ssbd_pkg::RECIP_W-1:0]  m;
    logic result_valid_reg, row_end_reg, frame_end_reg;
    logic wr_en;
    logic out_load;

    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign wr_en    = (state_reg == ST_SUM) && !cmd_reg.emit;
    assign m        = ssbd_pkg::recip(f);
    assign out_load = (state_reg == ST_OUT) && (!result_valid_reg || result_ready);

    // block total: this segment plus the rows above it
    always_comb
    begin
        for (int c = 0; c < ssbd_pkg::NUM_CH; c++)
        begin
            tot[c] = ssbd_pkg::SUM_W'(cmd_reg.run[c])
                   + (cmd_reg.use_mem ? rd_reg[c] : '0);
        end
    end

    // sum * 21 / 1024, then divide by 5*f*f through the reciprocal
    always_comb
    begin
        gained = '0;
        scaled = '0;
        for (int c = 0; c < ssbd_pkg::NUM_CH; c++)
        begin
            gained  = ssbd_pkg::GAIN_W'(tot_reg[c]) * ssbd_pkg::GAIN_W'(ssbd_pkg::GAIN_NUM);
            scaled  = gained[ssbd_pkg::GAIN_W-1:ssbd_pkg::GAIN_SHIFT];
            prod[c] = ssbd_pkg::PROD_W'(scaled) * ssbd_pkg::PROD_W'(m);
        end
    end

    // quotient and saturation at 255
    always_comb
    begin
        quot = '0;
        for (int c = 0; c < ssbd_pkg::NUM_CH; c++)
        begin
            quot   = prod_reg[c][ssbd_pkg::PROD_W-1:ssbd_pkg::RECIP_SHIFT];
            sat[c] = (quot > ssbd_pkg::QUOT_W'(255)) ? '1 : quot[ssbd_pkg::PIX_W-1:0];
        end
    end

    // column-sum memory, registered read
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rd_reg <= mem[q_head.col[IDXW-1:0]];
        end
        if (wr_en)
        begin
            mem[cmd_reg.col[IDXW-1:0]] <= tot;
        end
    end

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cmd_reg          <= '0;
            tot_reg          <= '0;
            prod_reg         <= '0;
            pix_reg          <= '0;
            row_end_reg      <= 1'b0;
            frame_end_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result replaces the one taken this cycle
            if (out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cmd_reg   <= q_head;
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM:
                begin
                    tot_reg   <= tot;
                    state_reg <= cmd_reg.emit ? ST_MUL : ST_IDLE;
                end
                ST_MUL:
                begin
                    prod_reg  <= prod;
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        pix_reg       <= sat;
                        row_end_reg   <= cmd_reg.row_end;
                        frame_end_reg <= cmd_reg.frame_end;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign red_out      = pix_reg[0];
    assign green_out    = pix_reg[1];
    assign blue_out     = pix_reg[2];
    assign row_end      = row_end_reg;
    assign frame_end    = frame_end_reg;

endmodule

`default_nettype wire

[hw/rtl/supersample_box_downscale.sv]
// Top level: configuration registers, front end, command queue and back end.
// A block's bottom-right pixel passes the command queue and the back end's sum,
// multiply and output states before its result is valid. Throughput: pixels enter
// one per cycle while the 4-entry queue has room; the back end runs a partial-sum
// update via idle and sum, a resolved pixel via idle, sum, multiply and output.
// Reset: registers to scale 1, 1024 x 768, counters cleared; column sums not cleared.
`timescale 1ns / 1ps
`default_nettype none

module supersample_box_downscale #(
    parameter int MAX_OUT_WIDTH = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [ssbd_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [ssbd_pkg::PDATA_W-1:0]       pwdata,
    output logic [ssbd_pkg::PDATA_W-1:0]            prdata,
    output logic                                    pready,
    input  wire logic                               pixel_valid,
    output logic                                    pixel_ready,
    input  wire logic [ssbd_pkg::CHANNEL_BITS-1:0]  red_in,
    input  wire logic [ssbd_pkg::CHANNEL_BITS-1:0]  green_in,
    input  wire logic [ssbd_pkg::CHANNEL_BITS-1:0]  blue_in,
    output logic                                    result_valid,
    input  wire logic                               result_ready,
    output logic [ssbd_pkg::PIX_W-1:0]              red_out,
    output logic [ssbd_pkg::PIX_W-1:0]              green_out,
    output logic [ssbd_pkg::PIX_W-1:0]              blue_out,
    output logic                                    row_end,
    output logic                                    frame_end
);

    logic [ssbd_pkg::SCALE_W-1:0]  scale_reg;
    logic [ssbd_pkg::WIDTH_W-1:0]  width_reg;
    logic [ssbd_pkg::HEIGHT_W-1:0] height_reg;
    logic [ssbd_pkg::DIM_W-1:0]    width_ext;
    ssbd_pkg::reg_idx_t            reg_sel;
    ssbd_pkg::cfg_t                cfg;
    ssbd_pkg::cmd_t                push_cmd, head;
    logic cfg_wr, push, pop, q_full, q_empty;

    assign pready  = 1'b1;
    assign reg_sel = ssbd_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // register file; any write restarts the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= ssbd_pkg::SCALE_W'(1);
            width_reg  <= ssbd_pkg::WIDTH_W'(1024);
            height_reg <= ssbd_pkg::HEIGHT_W'(768);
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                ssbd_pkg::REG_SCALE:  scale_reg  <= pwdata[ssbd_pkg::SCALE_W-1:0];
                ssbd_pkg::REG_WIDTH:  width_reg  <= pwdata[ssbd_pkg::WIDTH_W-1:0];
                ssbd_pkg::REG_HEIGHT: height_reg <= pwdata[ssbd_pkg::HEIGHT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_sel)
            ssbd_pkg::REG_SCALE:  prdata = ssbd_pkg::PDATA_W'(scale_reg);
            ssbd_pkg::REG_WIDTH:  prdata = ssbd_pkg::PDATA_W'(width_reg);
            ssbd_pkg::REG_HEIGHT: prdata = ssbd_pkg::PDATA_W'(height_reg);
            default:              prdata = '0;
        endcase
    end

    // clamp the settings into their working ranges
    assign width_ext = ssbd_pkg::DIM_W'(width_reg);
    always_comb
    begin
        if (scale_reg == '0)
            cfg.f = ssbd_pkg::SCALE_W'(1);
        else if (scale_reg > ssbd_pkg::SCALE_W'(ssbd_pkg::MAX_SCALE))
            cfg.f = ssbd_pkg::SCALE_W'(ssbd_pkg::MAX_SCALE);
        else
            cfg.f = scale_reg;

        if (width_ext == '0)
            cfg.w = ssbd_pkg::DIM_W'(1);
        else if (width_ext > ssbd_pkg::DIM_W'(MAX_OUT_WIDTH))
            cfg.w = ssbd_pkg::DIM_W'(MAX_OUT_WIDTH);
        else
            cfg.w = width_ext;

        if (height_reg == '0)
            cfg.h = ssbd_pkg::DIM_W'(1);
        else if (height_reg > ssbd_pkg::HEIGHT_W'(ssbd_pkg::MAX_OUT_HEIGHT))
            cfg.h = ssbd_pkg::DIM_W'(ssbd_pkg::MAX_OUT_HEIGHT);
        else
            cfg.h = ssbd_pkg::DIM_W'(height_reg);
    end

    ssbd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .restart     (cfg_wr),
        .cfg         (cfg),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .q_full      (q_full),
        .push        (push),
        .cmd         (push_cmd)
    );

    ssbd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    ssbd_back #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .f            (cfg.f),
        .q_empty      (q_empty),
        .q_pop        (pop),
        .q_head       (head),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .row_end      (row_end),
        .frame_end    (frame_end)
    );

endmodule

`default_nettype wire

[hw/rtl/ssbd_checker.sv]
// Port-level checks of the supersample box downscale and their bind.
`timescale 1ns / 1ps
`default_nettype none
`include "supersample_box_downscale_macros.svh"

module ssbd_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          psel,
    input wire logic                          penable,
    input wire logic                          pwrite,
    input wire logic [ssbd_pkg::PADDR_W-1:0]  paddr,
    input wire logic [ssbd_pkg::PDATA_W-1:0]  pwdata,
    input wire logic [ssbd_pkg::PDATA_W-1:0]  prdata,
    input wire logic                          pready,
    input wire logic                          result_valid,
    input wire logic                          result_ready,
    input wire logic [ssbd_pkg::PIX_W-1:0]    red_out,
    input wire logic [ssbd_pkg::PIX_W-1:0]    green_out,
    input wire logic [ssbd_pkg::PIX_W-1:0]    blue_out,
    input wire logic                          row_end,
    input wire logic                          frame_end
);

    // stalled result holds
    `SSBD_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(red_out) && $stable(green_out) && $stable(blue_out) && $stable(row_end) && $stable(frame_end))

    // the last pixel of a frame also closes its row
    `SSBD_ASSERT_SAME(a_frame_closes_row, result_valid && frame_end, row_end)

    // scale and width read back what was written, masked to their fields
    `SSBD_ASSERT_NEXT(a_scale_readback, psel && penable && pwrite && pready && paddr[3:2] == ssbd_pkg::REG_SCALE, paddr[3:2] != ssbd_pkg::REG_SCALE || prdata == 32'($past(pwdata[3:0])))
    `SSBD_ASSERT_NEXT(a_width_readback, psel && penable && pwrite && pready && paddr[3:2] == ssbd_pkg::REG_WIDTH, paddr[3:2] != ssbd_pkg::REG_WIDTH || prdata == 32'($past(pwdata[10:0])))

endmodule

bind supersample_box_downscale ssbd_checker u_ssbd_checker (.*);

`default_nettype wire

[dv/supersample_box_downscale_test.sv]
// Self-checking testbench for the supersample box downscale block.
`timescale 1ns / 1ps

module supersample_box_downscale_test;

    localparam int MAX_OUT_WIDTH  = 1024;
    localparam int BOOST_NUM      = 21;
    localparam int BOOST_DEN      = 20;
    localparam int FRAC_ONE       = 256;
    localparam int PIX_MAX        = 255;
    localparam int IDLE_PERCENT   = 19;
    localparam int SETTLE_CYCLES  = 40;
    localparam int STALL_LIMIT    = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_REQS    = 200;
    localparam int PARTIAL_MAX    = 200;
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [ssbd_pkg::CHANNEL_BITS-1:0] red;
        logic [ssbd_pkg::CHANNEL_BITS-1:0] green;
        logic [ssbd_pkg::CHANNEL_BITS-1:0] blue;
    } hires_pixel_t;

    typedef struct packed {
        logic [ssbd_pkg::PIX_W-1:0] red;
        logic [ssbd_pkg::PIX_W-1:0] green;
        logic [ssbd_pkg::PIX_W-1:0] blue;
        logic                       row_end;
        logic                       frame_end;
    } out_pixel_t;

    // Block ports; the inputs known from time zero
    logic                              clk          = 1'b0;
    logic                              rst_n        = 1'b0;
    logic                              psel         = 1'b0;
    logic                              penable      = 1'b0;
    logic                              pwrite       = 1'b0;
    logic [ssbd_pkg::PADDR_W-1:0]      paddr        = '0;
    logic [ssbd_pkg::PDATA_W-1:0]      pwdata       = '0;
    logic [ssbd_pkg::PDATA_W-1:0]      prdata;
    logic                              pready;
    logic                              pixel_valid  = 1'b0;
    logic                              pixel_ready;
    logic [ssbd_pkg::CHANNEL_BITS-1:0] red_in       = '0;
    logic [ssbd_pkg::CHANNEL_BITS-1:0] green_in     = '0;
    logic [ssbd_pkg::CHANNEL_BITS-1:0] blue_in      = '0;
    logic                              result_valid;
    logic                              result_ready = 1'b0;
    logic [ssbd_pkg::PIX_W-1:0]        red_out;
    logic [ssbd_pkg::PIX_W-1:0]        green_out;
    logic [ssbd_pkg::PIX_W-1:0]        blue_out;
    logic                              row_end;
    logic                              frame_end;

    wire pixel_taken  = pixel_valid && pixel_ready;
    wire result_taken = result_valid && result_ready;

    // Shadow of the configuration and of the resolve state
    logic [ssbd_pkg::SCALE_W-1:0]  cfg_scale  = 4'd1;
    logic [ssbd_pkg::WIDTH_W-1:0]  cfg_width  = 11'd1024;
    logic [ssbd_pkg::HEIGHT_W-1:0] cfg_height = 13'd768;
    logic [ssbd_pkg::SUM_W-1:0]    column_sum [MAX_OUT_WIDTH][ssbd_pkg::NUM_CH];
    logic [ssbd_pkg::RUN_W-1:0]    run_sum [ssbd_pkg::NUM_CH] = '{default: '0};
    int unsigned                   sub_col = 0;
    int unsigned                   sub_row = 0;
    int unsigned                   out_col = 0;
    int unsigned                   out_row = 0;

    out_pixel_t pending_out_pixels [$];
    int         error_count  = 0;
    bit         no_idle      = 1'b0;
    int         hold_request = 0;
    int         hold_left    = 0;
    int         idle_cycles  = 0;

    supersample_box_downscale #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .row_end      (row_end),
        .frame_end    (frame_end)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Zero acts as one, anything above the limit acts as the limit
    function automatic int effective_setting(input int raw, input int hi);
        if (raw == 0)
        begin
            return 1;
        end
        if (raw > hi)
        begin
            return hi;
        end
        return raw;
    endfunction

    // floor(sum * 1.05 / f^2) on Q8.8 sums, saturated
    function automatic logic [ssbd_pkg::PIX_W-1:0] resolve_channel(
        input logic [ssbd_pkg::SUM_W-1:0] sum,
        input int f);
        longint q;
        q = (longint'(sum) * BOOST_NUM) / (longint'(BOOST_DEN) * FRAC_ONE * f * f);
        return (q > PIX_MAX) ? ssbd_pkg::PIX_W'(PIX_MAX) : ssbd_pkg::PIX_W'(q);
    endfunction

    // Box-sum one accepted high-res pixel; queue the output pixel it completes
    function automatic void box_accumulate(input hires_pixel_t px);
        logic [ssbd_pkg::CHANNEL_BITS-1:0] chan [ssbd_pkg::NUM_CH];
        logic [ssbd_pkg::SUM_W-1:0]        total [ssbd_pkg::NUM_CH];
        int                                f;
        int                                w;
        int                                h;
        bit                                last_col;
        bit                                last_row;
        out_pixel_t                        res;
        f = effective_setting(int'(cfg_scale), ssbd_pkg::MAX_SCALE);
        w = effective_setting(int'(cfg_width), MAX_OUT_WIDTH);
        h = effective_setting(int'(cfg_height), ssbd_pkg::MAX_OUT_HEIGHT);
        chan[0] = px.red;
        chan[1] = px.green;
        chan[2] = px.blue;
        for (int c = 0; c < ssbd_pkg::NUM_CH; c++)
        begin
            run_sum[c] += ssbd_pkg::RUN_W'(chan[c]);
        end
        if (sub_col + 1 < f)
        begin
            sub_col++;
            return;
        end
        sub_col = 0;

        // close the block-row segment; rows past the first add the column sum
        for (int c = 0; c < ssbd_pkg::NUM_CH; c++)
        begin
            total[c] = ssbd_pkg::SUM_W'(run_sum[c]);
            if (sub_row != 0)
            begin
                total[c] += column_sum[out_col][c];
            end
            run_sum[c] = '0;
        end
        last_col = (out_col + 1 >= w);
        last_row = (out_row + 1 >= h);

        if (sub_row + 1 >= f)
        begin
            res.red       = resolve_channel(total[0], f);
            res.green     = resolve_channel(total[1], f);
            res.blue      = resolve_channel(total[2], f);
            res.row_end   = last_col;
            res.frame_end = last_col && last_row;
            pending_out_pixels.push_back(res);
        end
        else
        begin
            for (int c = 0; c < ssbd_pkg::NUM_CH; c++)
            begin
                column_sum[out_col][c] = total[c];
            end
        end

        // walk the output position
        if (!last_col)
        begin
            out_col++;
            return;
        end
        out_col = 0;
        if (sub_row + 1 < f)
        begin
            sub_row++;
            return;
        end
        sub_row = 0;
        out_row = last_row ? 0 : out_row + 1;
    endfunction

    // Result side: random ready, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // Compare each taken result with the oldest predicted one
    always @(posedge clk)
    begin
        out_pixel_t want;
        if (rst_n && result_taken)
        begin
            if (pending_out_pixels.size() == 0)
            begin
                $error("unexpected result: red %0d green %0d blue %0d",
                       red_out, green_out, blue_out);
                error_count++;
            end
            else
            begin
                want = pending_out_pixels.pop_front();
                if (red_out !== want.red)
                begin
                    $error("red_out: expected %0d, got %0d", want.red, red_out);
                    error_count++;
                end
                if (green_out !== want.green)
                begin
                    $error("green_out: expected %0d, got %0d", want.green, green_out);
                    error_count++;
                end
                if (blue_out !== want.blue)
                begin
                    $error("blue_out: expected %0d, got %0d", want.blue, blue_out);
                    error_count++;
                end
                if (row_end !== want.row_end)
                begin
                    $error("row_end: expected %0d, got %0d", want.row_end, row_end);
                    error_count++;
                end
                if (frame_end !== want.frame_end)
                begin
                    $error("frame_end: expected %0d, got %0d", want.frame_end, frame_end);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no request or result moving
    always @(posedge clk)
    begin
        if (pixel_taken || result_taken)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("supersample_box_downscale_test: errors");
                $finish;
            end
        end
    end

    // APB write: setup, access, then idle
    task automatic write_register(input logic [1:0] index,
                                  input logic [ssbd_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ssbd_pkg::PADDR_W'({index, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            ssbd_pkg::REG_SCALE:  cfg_scale  = value[ssbd_pkg::SCALE_W-1:0];
            ssbd_pkg::REG_WIDTH:  cfg_width  = value[ssbd_pkg::WIDTH_W-1:0];
            ssbd_pkg::REG_HEIGHT: cfg_height = value[ssbd_pkg::HEIGHT_W-1:0];
            default: ;
        endcase
        // any write restarts the frame; column sums survive
        run_sum = '{default: '0};
        sub_col = 0;
        sub_row = 0;
        out_col = 0;
        out_row = 0;
        @(posedge clk);
    endtask

    task automatic set_frame(input int scale, input int width, input int height);
        write_register(ssbd_pkg::REG_SCALE, ssbd_pkg::PDATA_W'(scale));
        write_register(ssbd_pkg::REG_WIDTH, ssbd_pkg::PDATA_W'(width));
        write_register(ssbd_pkg::REG_HEIGHT, ssbd_pkg::PDATA_W'(height));
    endtask

    // One pixel request; valid stays up across back-to-back requests
    task automatic send_pixel(input hires_pixel_t px);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        red_in      <= px.red;
        green_in    <= px.green;
        blue_in     <= px.blue;
        do @(posedge clk); while (!pixel_ready);
        box_accumulate(px);
    endtask

    // Drop valid, drain expected results, let queued partial-sum work finish
    task automatic settle();
        pixel_valid <= 1'b0;
        while (pending_out_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [ssbd_pkg::CHANNEL_BITS-1:0] random_channel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return ssbd_pkg::CHANNEL_BITS'($urandom_range(0, 16'hF2FF));
            default: return ssbd_pkg::CHANNEL_BITS'($urandom());
        endcase
    endfunction

    function automatic hires_pixel_t random_pixel();
        hires_pixel_t px;
        px.red   = random_channel();
        px.green = random_channel();
        px.blue  = random_channel();
        return px;
    endfunction

    // Reset configuration: scale 1, 1024 wide, each pixel resolves on its own
    task automatic test_reset_defaults();
        repeat (6) send_pixel(random_pixel());
        settle();
    endtask

    // Channel extremes and truncation edges at scale 1 and 2
    task automatic test_directed_extremes();
        set_frame(1, 1, 1);
        send_pixel('{red: 16'h0000, green: 16'h0000, blue: 16'h0000});
        send_pixel('{red: 16'hFFFF, green: 16'hFFFF, blue: 16'hFFFF});
        send_pixel('{red: 16'h00F3, green: 16'h00F4, blue: 16'h0100});
        send_pixel('{red: 16'hF2FF, green: 16'h8000, blue: 16'h7FFF});
        settle();
        // two columns, one block row: column sums carried per column
        set_frame(2, 2, 1);
        send_pixel('{red: 16'hFFFF, green: 16'h0000, blue: 16'h5555});
        send_pixel('{red: 16'hFFFF, green: 16'h0001, blue: 16'hAAAA});
        send_pixel('{red: 16'h0100, green: 16'hFFFF, blue: 16'h0000});
        send_pixel('{red: 16'h0200, green: 16'hFFFE, blue: 16'h00FF});
        send_pixel('{red: 16'hFFFF, green: 16'h8001, blue: 16'h1234});
        send_pixel('{red: 16'hFFFF, green: 16'h7FFE, blue: 16'hEDCB});
        send_pixel('{red: 16'h0300, green: 16'h0000, blue: 16'hFF00});
        send_pixel('{red: 16'h0400, green: 16'h0000, blue: 16'h00FF});
        settle();
    endtask

    // A write to the spare address mid-frame restarts the block position
    task automatic test_frame_restart();
        set_frame(2, 1, 1);
        repeat (2) send_pixel(random_pixel());
        settle();
        write_register(REG_SPARE, 32'hFFFF_FFFF);
        repeat (4) send_pixel(random_pixel());
        settle();
    endtask

    // Oversized width clamps to the full row, zero height to one row; no idling
    task automatic test_wide_row();
        set_frame(1, 2047, 0);
        no_idle = 1'b1;
        repeat (MAX_OUT_WIDTH) send_pixel(random_pixel());
        no_idle = 1'b0;
        settle();
    endtask

    // Results held off long enough for the block to stall its input
    task automatic test_backpressure();
        set_frame(1, 4, 8);
        hold_request = HOLD_CYCLES;
        repeat (32) send_pixel(random_pixel());
        settle();
    endtask

    // Random configurations; small frames sent whole, partial or twice, large ones partial
    task automatic test_random_frames();
        int         sent;
        int         pick;
        int         f;
        int         frame_pixels;
        int         count;
        logic [ssbd_pkg::SCALE_W-1:0]  scale_raw;
        logic [ssbd_pkg::WIDTH_W-1:0]  width_raw;
        logic [ssbd_pkg::HEIGHT_W-1:0] height_raw;
        sent = 0;
        while (sent < RANDOM_REQS)
        begin
            no_idle = (sent >= 40 && sent < 120);

            pick = $urandom_range(0, 99);
            if (pick < 70)
                scale_raw = ssbd_pkg::SCALE_W'($urandom_range(1, 4));
            else if (pick < 80)
                scale_raw = ssbd_pkg::SCALE_W'(ssbd_pkg::MAX_SCALE);
            else if (pick < 90)
                scale_raw = '0;
            else
                scale_raw = ssbd_pkg::SCALE_W'($urandom_range(ssbd_pkg::MAX_SCALE + 1, 15));

            pick = $urandom_range(0, 99);
            if (pick < 80)      width_raw = ssbd_pkg::WIDTH_W'($urandom_range(1, 6));
            else if (pick < 90) width_raw = '0;
            else                width_raw = ssbd_pkg::WIDTH_W'($urandom_range(7, 2047));

            pick = $urandom_range(0, 99);
            if (pick < 80)      height_raw = ssbd_pkg::HEIGHT_W'($urandom_range(1, 3));
            else if (pick < 90) height_raw = '0;
            else                height_raw = ssbd_pkg::HEIGHT_W'($urandom_range(4, 8191));

            set_frame(int'(scale_raw), int'(width_raw), int'(height_raw));
            if ($urandom_range(0, 99) < 15)
            begin
                write_register(REG_SPARE, $urandom());
            end

            f = effective_setting(int'(scale_raw), ssbd_pkg::MAX_SCALE);
            frame_pixels = effective_setting(int'(width_raw), MAX_OUT_WIDTH) * f
                         * effective_setting(int'(height_raw), ssbd_pkg::MAX_OUT_HEIGHT) * f;
            pick = $urandom_range(0, 99);
            if (frame_pixels > PARTIAL_MAX)
                count = $urandom_range(1, PARTIAL_MAX);
            else if (pick < 20)
                count = $urandom_range(1, frame_pixels);
            else if (pick < 50)
                count = 2 * frame_pixels;
            else
                count = frame_pixels;

            repeat (count) send_pixel(random_pixel());
            sent += count;
            settle();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed_extremes();
        test_frame_restart();
        test_wide_row();
        test_backpressure();
        test_random_frames();
        if (error_count == 0)
        begin
            $display("supersample_box_downscale_test: clean");
        end
        else
        begin
            $display("supersample_box_downscale_test: errors");
        end
        $finish;
    end

endmodule
